// ===== hw/rtl/sensor_word_crc_check_and_convert_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Sensor word check and convert: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SENSOR_WORD_CRC_CHECK_AND_CONVERT_UNIT_DEFINES_SVH
`define SENSOR_WORD_CRC_CHECK_AND_CONVERT_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SWCC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swcc assertion failed");

// antecedent implies consequent in the following cycle
`define SWCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swcc assertion failed");

`endif

// ===== hw/rtl/swcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Sensor word check and convert: package
// Constants, status codes, CRC-8 byte step and the check-to-convert item type.
// ----------------------------------------------------------------------------
package swcc_pkg;

  localparam logic [7:0]  CRC_POLY   = 8'h31;
  localparam logic [15:0] RAW_MASK   = 16'hFFFC;
  localparam int          STATUS_BIT = 1;

  localparam logic [14:0] T_SCALE  = 15'd17572;
  localparam logic [14:0] H_SCALE  = 15'd12500;
  localparam logic [15:0] T_OFFSET = 16'd4685;
  localparam logic [15:0] H_OFFSET = 16'd600;

  localparam logic KIND_TEMP = 1'b0;
  localparam logic KIND_HUM  = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_KIND = 2'd1;
  localparam logic [1:0] ST_CRC  = 2'd2;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [1:0]  status;
    logic [15:0] raw;
  } chk_item_t;

  // one byte through the CRC-8, MSB first
  function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/swcc_check.sv =====
// ----------------------------------------------------------------------------
// Sensor word check
// Two stages: CRC over the high byte, then CRC over the low byte with the
// status bit and CRC comparison.
// ----------------------------------------------------------------------------
`include "sensor_word_crc_check_and_convert_unit_defines.svh"

module swcc_check (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_go,
  input  logic                 in_kind,
  input  logic [7:0]           in_data_high,
  input  logic [7:0]           in_data_low,
  input  logic [7:0]           in_check_byte,
  output swcc_pkg::chk_item_t  item_o
);

  // stage 1
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_kind_r;
  logic [7:0] s1_high_r;
  logic [7:0] s1_low_r;
  logic [7:0] s1_chk_r;
  logic [7:0] s1_crc_r, s1_crc_nxt;

  // stage 2
  swcc_pkg::chk_item_t s2_r, s2_nxt;
  logic [7:0]          crc_full;
  logic                flag;

  assign s1_valid_nxt = in_go;
  assign s1_crc_nxt   = swcc_pkg::crc_byte(8'h00, in_data_high);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    s1_kind_r <= in_kind;
    s1_high_r <= in_data_high;
    s1_low_r  <= in_data_low;
    s1_chk_r  <= in_check_byte;
    s1_crc_r  <= s1_crc_nxt;
  end

  always_comb begin
    crc_full      = swcc_pkg::crc_byte(s1_crc_r, s1_low_r);
    flag          = s1_low_r[swcc_pkg::STATUS_BIT];
    s2_nxt.valid  = s1_valid_r;
    s2_nxt.kind   = s1_kind_r;
    s2_nxt.raw    = {s1_high_r, s1_low_r} & swcc_pkg::RAW_MASK;
    if (flag != s1_kind_r) begin
      s2_nxt.status = swcc_pkg::ST_KIND;
    end else if (crc_full != s1_chk_r) begin
      s2_nxt.status = swcc_pkg::ST_CRC;
    end else begin
      s2_nxt.status = swcc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else begin
      s2_r.valid <= s2_nxt.valid;
    end
    s2_r.kind   <= s2_nxt.kind;
    s2_r.status <= s2_nxt.status;
    s2_r.raw    <= s2_nxt.raw;
  end

  assign item_o = s2_r;

  `SWCC_ASSERT_NEXT(a_chk_valid_flow, in_go, s1_valid_r)
  `SWCC_ASSERT_NOW(a_chk_raw_masked, s2_r.valid, s2_r.raw[1:0] == 2'b00)
  `SWCC_ASSERT_NOW(a_chk_status_kind,
    s2_r.valid && (s2_r.status == swcc_pkg::ST_OK || s2_r.status == swcc_pkg::ST_CRC),
    s2_r.kind == $past(s1_low_r[swcc_pkg::STATUS_BIT]))

endmodule

// ===== hw/rtl/swcc_convert.sv =====
// ----------------------------------------------------------------------------
// Sensor word convert
// Two stages: scale multiply, then offset subtract and result register.
// ----------------------------------------------------------------------------
`include "sensor_word_crc_check_and_convert_unit_defines.svh"

module swcc_convert (
  input  logic                clk,
  input  logic                rst_n,
  input  swcc_pkg::chk_item_t item_i,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic signed [14:0]  out_reading,
  output logic [15:0]         out_masked_raw
);

  // stage 3
  logic        s3_valid_r, s3_valid_nxt;
  logic        s3_kind_r;
  logic [1:0]  s3_status_r;
  logic [15:0] s3_raw_r;
  logic [14:0] s3_prod_hi_r, s3_prod_hi_nxt;
  logic [14:0] scale;
  logic [30:0] prod;

  // stage 4
  logic               s4_valid_r;
  logic [1:0]         s4_status_r;
  logic signed [14:0] s4_reading_r, s4_reading_nxt;
  logic [15:0]        s4_raw_r;
  logic [15:0]        offset;
  logic [15:0]        diff;

  assign scale          = (item_i.kind == swcc_pkg::KIND_HUM) ? swcc_pkg::H_SCALE
                                                              : swcc_pkg::T_SCALE;
  assign prod           = {15'd0, item_i.raw} * {16'd0, scale};
  assign s3_prod_hi_nxt = prod[30:16];
  assign s3_valid_nxt   = item_i.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s3_valid_nxt;
    end
    s3_kind_r    <= item_i.kind;
    s3_status_r  <= item_i.status;
    s3_raw_r     <= item_i.raw;
    s3_prod_hi_r <= s3_prod_hi_nxt;
  end

  assign offset = (s3_kind_r == swcc_pkg::KIND_HUM) ? swcc_pkg::H_OFFSET
                                                    : swcc_pkg::T_OFFSET;
  assign diff   = {1'b0, s3_prod_hi_r} - offset;

  always_comb begin
    if (s3_status_r == swcc_pkg::ST_OK) begin
      s4_reading_nxt = $signed(diff[14:0]);
    end else begin
      s4_reading_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
    s4_status_r  <= s3_status_r;
    s4_reading_r <= s4_reading_nxt;
    s4_raw_r     <= s3_raw_r;
  end

  assign out_valid      = s4_valid_r;
  assign out_status     = s4_status_r;
  assign out_reading    = s4_reading_r;
  assign out_masked_raw = s4_raw_r;

  `SWCC_ASSERT_NOW(a_cvt_err_zero, s4_valid_r && (s4_status_r != swcc_pkg::ST_OK),
    s4_reading_r == 15'sd0)
  `SWCC_ASSERT_NOW(a_cvt_status_code, s4_valid_r, s4_status_r != 2'd3)
  `SWCC_ASSERT_NEXT(a_cvt_valid_flow, s3_valid_r, s4_valid_r)

endmodule

// ===== hw/rtl/sensor_word_crc_check_and_convert_unit.sv =====
// A transaction taken at start passes through the stage 1 to stage 4 registers to its result strobe.
// Throughput: one transaction per cycle; the four pipeline registers never stall.
// busy is always low; results cannot be held off by the receiver.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// Sensor word CRC check and convert unit
// Checks status bit and CRC-8 of a three-byte sensor reply and converts the
// masked raw word to hundredths of a degree or percent.
// ----------------------------------------------------------------------------
module sensor_word_crc_check_and_convert_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_kind,
  input  logic [7:0]         in_data_high,
  input  logic [7:0]         in_data_low,
  input  logic [7:0]         in_check_byte,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic signed [14:0] out_reading,
  output logic [15:0]        out_masked_raw
);

  swcc_pkg::chk_item_t chk_item;
  logic                go;

  assign busy = 1'b0;
  assign go   = start && !busy;

  swcc_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_go         (go),
    .in_kind       (in_kind),
    .in_data_high  (in_data_high),
    .in_data_low   (in_data_low),
    .in_check_byte (in_check_byte),
    .item_o        (chk_item)
  );

  swcc_convert u_convert (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_i         (chk_item),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_reading    (out_reading),
    .out_masked_raw (out_masked_raw)
  );

endmodule
